// ----- hdl/ltb_pkg.sv -----
package ltb_pkg;

    // Field widths fixed by the data format.
    localparam int VAL_W     = 18;
    localparam int ROW_W     = 6;
    localparam int DIMS_W    = 2;
    localparam int DEG_W     = 3;
    localparam int RECIP_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 3;

    // Saturation limits of an 18-bit signed value.
    localparam int VAL_MAX = 131071;
    localparam int VAL_MIN = -131072;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMS   = 1'b0,
        REG_DEGREE = 1'b1
    } t_reg_idx;

    // The dims code that selects three coordinates.
    localparam logic [DIMS_W-1:0] DIMS_3D = 2'd3;

    // Unsigned Q0.16 reciprocals of the recurrence divisor k+1.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] r);
        logic [RECIP_W-1:0] v;
        case (r)
            3'd2: v = 16'd32768;
            3'd3: v = 16'd21845;
            3'd4: v = 16'd16384;
            3'd5: v = 16'd13107;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value into the 18-bit range.
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'(VAL_MAX)) begin
            r = VAL_W'(VAL_MAX);
        end else if (v < 64'(VAL_MIN)) begin
            r = VAL_W'(VAL_MIN);
        end else begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hdl/ltb_if.sv -----
// Point channel: one transaction carries one input point.
interface ltb_pt_if import ltb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] x_coord;
    logic signed [VAL_W-1:0] y_coord;
    logic signed [VAL_W-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface

// Result channel: one transaction carries one basis value.
interface ltb_res_if import ltb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] basis_value;
    logic [ROW_W-1:0]        basis_index;
    logic                    last;

    modport source (output valid, output basis_value, output basis_index, output last,
                    input ready);
    modport sink   (input valid, input basis_value, input basis_index, input last,
                    output ready);
endinterface

// Configuration write channel.
interface ltb_cfg_if import ltb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ltb_queue.sv -----
module ltb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/ltb_front.sv -----
module ltb_front import ltb_pkg::*; #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 16,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ltb_pt_if.sink             i_pt,
    input  logic [IDX_W-1:0]   i_degree,
    input  logic               i_three,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output logic [ENTRY_W-1:0] o_push_data
);

    localparam int ND    = MAX_DEGREE + 1;
    localparam int M_W   = 2 * VAL_W;
    localparam int P_W   = M_W + 4;
    localparam int NUM_W = (((P_W - FRAC_BITS) > (VAL_W + 4)) ?
                            (P_W - FRAC_BITS) : (VAL_W + 4)) + 1;
    localparam int Q_W   = NUM_W + RECIP_W + 1;
    localparam int ONE_I = (FRAC_BITS >= VAL_W - 1) ? VAL_MAX : (1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(ONE_I);
    localparam logic signed [P_W-1:0]   HALF_F  = P_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0]   HALF_R  = Q_W'(1) <<< (RECIP_W - 1);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_ACC  = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate                 r_state;
    t_fstate                 n_state;
    logic                    r_pend_valid;
    logic signed [VAL_W-1:0] r_pend_t [3];
    logic signed [VAL_W-1:0] r_t [3];
    logic signed [VAL_W-1:0] r_p [3][ND];
    logic signed [M_W-1:0]   r_m [3];
    logic signed [NUM_W-1:0] r_num [3];
    logic [IDX_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_d;
    logic                    r_three;

    logic [IDX_W:0]          w_k_next;
    logic signed [P_W-1:0]   w_scaled [3];
    logic signed [P_W-1:0]   w_round [3];
    logic signed [NUM_W-1:0] w_kp [3];
    logic signed [Q_W-1:0]   w_q [3];
    logic signed [Q_W-1:0]   w_div [3];
    logic                    w_take;

    // The pending register takes a point while the previous one is still in work.
    assign i_pt.ready = !r_pend_valid;
    assign w_take     = i_pt.valid && !r_pend_valid;
    assign w_k_next   = {1'b0, r_k} + {{IDX_W{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_take) begin
            r_pend_valid <= 1'b1;
        end else if (r_state == F_IDLE) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pend_t[0] <= i_pt.x_coord;
            r_pend_t[1] <= i_pt.y_coord;
            r_pend_t[2] <= i_pt.z_coord;
        end
    end

    // Recurrence arithmetic, one lane per axis.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_scaled[a] = P_W'(r_m[a]) * $signed({1'b0, r_k, 1'b1});
            w_round[a]  = (w_scaled[a] + HALF_F) >>> FRAC_BITS;
            w_kp[a]     = NUM_W'(r_p[a][r_k - IDX_W'(1)]) * $signed({1'b0, r_k});
            w_q[a]      = Q_W'(r_num[a]) * $signed({1'b0, recip_of(3'(w_k_next))});
            w_div[a]    = (w_q[a] + HALF_R) >>> RECIP_W;
        end
    end

    // Sequencer: load, then (multiply, accumulate, divide) per degree step, then push.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (r_pend_valid) begin
                    n_state = ({1'b0, i_degree} >= (IDX_W + 1)'(2)) ? F_MUL : F_PUSH;
                end
            end
            F_MUL: n_state = F_ACC;
            F_ACC: n_state = F_DIV;
            F_DIV: begin
                n_state = (w_k_next < {1'b0, r_d}) ? F_MUL : F_PUSH;
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lane datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (r_pend_valid) begin
                    r_k     <= IDX_W'(1);
                    r_d     <= i_degree;
                    r_three <= i_three;
                    for (int a = 0; a < 3; a++) begin
                        r_t[a]    <= r_pend_t[a];
                        r_p[a][0] <= ONE_VAL;
                        r_p[a][1] <= r_pend_t[a];
                    end
                end
            end
            F_MUL: begin
                for (int a = 0; a < 3; a++) begin
                    r_m[a] <= r_t[a] * r_p[a][r_k];
                end
            end
            F_ACC: begin
                for (int a = 0; a < 3; a++) begin
                    r_num[a] <= NUM_W'(w_round[a]) - w_kp[a];
                end
            end
            F_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    r_p[a][w_k_next[IDX_W-1:0]] <= sat_val(64'(w_div[a]));
                end
                r_k <= w_k_next[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Pack the three value rows and the item's configuration for the queue.
    assign o_push_valid = (r_state == F_PUSH);

    always_comb begin
        o_push_data = '0;
        for (int a = 0; a < 3; a++) begin
            for (int e = 0; e < ND; e++) begin
                o_push_data[(a * ND + e) * VAL_W +: VAL_W] = r_p[a][e];
            end
        end
        o_push_data[3 * ND * VAL_W +: IDX_W] = r_d;
        o_push_data[ENTRY_W-1]              = r_three;
    end

endmodule

// ----- hdl/ltb_back.sv -----
module ltb_back import ltb_pkg::*; #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 16,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  logic [ENTRY_W-1:0] i_q_data,
    ltb_res_if.source          o_res
);

    localparam int ND  = MAX_DEGREE + 1;
    localparam int M_W = 2 * VAL_W;
    localparam logic signed [63:0] HALF_1 = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] HALF_2 = 64'sd1 <<< (2 * FRAC_BITS - 1);

    // Working entry and index generator.
    logic                    r_act;
    logic signed [VAL_W-1:0] r_p [3][ND];
    logic [IDX_W-1:0]        r_d;
    logic                    r_three;
    logic [IDX_W-1:0]        r_n;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_j;
    logic [ROW_W-1:0]        r_row;

    // Product pipeline.
    logic                        r_v1, r_v2, r_v3;
    logic signed [VAL_W-1:0]     r_a1, r_b1, r_c1;
    logic signed [M_W-1:0]       r_ab2;
    logic signed [VAL_W-1:0]     r_c2;
    logic signed [M_W:0]         r_lo3;
    logic signed [M_W-1:0]       r_hi3;
    logic signed [M_W-1:0]       r_ab3;
    logic [ROW_W-1:0]            r_row1, r_row2, r_row3;
    logic                        r_last1, r_last2, r_last3;
    logic                        r_three1, r_three2, r_three3;

    // Output register.
    logic                        r_ov;
    logic signed [VAL_W-1:0]     r_value;
    logic [ROW_W-1:0]            r_index;
    logic                        r_last;

    logic                        w_adv;
    logic                        w_emit;
    logic                        w_last;
    logic                        w_load;
    logic [IDX_W-1:0]            w_y;
    logic [IDX_W-1:0]            w_z;
    logic [IDX_W-1:0]            w_rest;
    logic signed [63:0]          w_sum;
    logic signed [63:0]          w_rnd;

    assign w_adv  = !r_ov || o_res.ready;
    assign w_emit = r_act && w_adv;
    assign w_rest = r_n - r_i;
    assign w_last = (r_i == r_n) && (r_n == r_d) && (!r_three || (r_j == '0));
    assign w_load = i_q_valid && (!r_act || (w_emit && w_last));
    assign o_q_ready = w_load;

    // Axis indexes of the current basis function.
    always_comb begin
        if (r_three) begin
            w_y = r_j;
            w_z = w_rest - r_j;
        end else begin
            w_y = w_rest;
            w_z = '0;
        end
    end

    // Generator: total degree outer, then x index, then y index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (w_load) begin
            r_act <= 1'b1;
        end else if (w_emit && w_last) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int a = 0; a < 3; a++) begin
                for (int e = 0; e < ND; e++) begin
                    r_p[a][e] <= i_q_data[(a * ND + e) * VAL_W +: VAL_W];
                end
            end
            r_d     <= i_q_data[3 * ND * VAL_W +: IDX_W];
            r_three <= i_q_data[ENTRY_W-1];
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_row   <= '0;
        end else if (w_emit) begin
            r_row <= r_row + 1'b1;
            if (r_three && (r_j != w_rest)) begin
                r_j <= r_j + 1'b1;
            end else if (r_i != r_n) begin
                r_i <= r_i + 1'b1;
                r_j <= '0;
            end else begin
                r_n <= r_n + 1'b1;
                r_i <= '0;
                r_j <= '0;
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= r_act;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // Final rounding: one shift of the exact product, then saturation.
    always_comb begin
        w_sum = (64'(r_hi3) <<< VAL_W) + 64'(r_lo3);
        if (r_three3) begin
            w_rnd = (w_sum + HALF_2) >>> (2 * FRAC_BITS);
        end else begin
            w_rnd = (64'(r_ab3) + HALF_1) >>> FRAC_BITS;
        end
    end

    // Operand fetch, x*y product, split product with z, output stage.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a1     <= r_p[0][r_i];
            r_b1     <= r_p[1][w_y];
            r_c1     <= r_p[2][w_z];
            r_row1   <= r_row;
            r_last1  <= w_last;
            r_three1 <= r_three;

            r_ab2    <= r_a1 * r_b1;
            r_c2     <= r_c1;
            r_row2   <= r_row1;
            r_last2  <= r_last1;
            r_three2 <= r_three1;

            r_lo3    <= $signed({1'b0, r_ab2[VAL_W-1:0]}) * r_c2;
            r_hi3    <= $signed(r_ab2[M_W-1:VAL_W]) * r_c2;
            r_ab3    <= r_ab2;
            r_row3   <= r_row2;
            r_last3  <= r_last2;
            r_three3 <= r_three2;

            r_value  <= sat_val(w_rnd);
            r_index  <= r_row3;
            r_last   <= r_last3;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.basis_value = r_value;
    assign o_res.basis_index = r_index;
    assign o_res.last        = r_last;

endmodule

// ----- hdl/legendre_tensor_basis_eval_unit.sv -----
// Throughput: one result per cycle while the result port is not stalled, limited by the
// output port and by the multiply, accumulate and divide recurrence step of the front.
// Reset: i_rst_n is synchronous, active low; it empties the pipeline and the queue and
// sets dims to 2 and degree to 2.
module legendre_tensor_basis_eval_unit import ltb_pkg::*; #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ltb_pt_if.sink     i_pt,
    ltb_cfg_if.sink    i_cfg,
    ltb_res_if.source  o_res
);

    localparam int ND      = MAX_DEGREE + 1;
    localparam int IDX_W   = $clog2(ND);
    localparam int ENTRY_W = 3 * ND * VAL_W + IDX_W + 1;
    localparam int QDEPTH  = 2;

    logic [DIMS_W-1:0]  r_dims;
    logic [DEG_W-1:0]   r_degree;
    logic [IDX_W-1:0]   w_deg_clamped;
    logic               w_three;
    logic               w_push_valid;
    logic               w_push_ready;
    logic [ENTRY_W-1:0] w_push_data;
    logic               w_pop_valid;
    logic               w_pop_ready;
    logic [ENTRY_W-1:0] w_pop_data;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= DIMS_W'(2);
            r_degree <= DEG_W'(2);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_DIMS:   r_dims   <= i_cfg.data[DIMS_W-1:0];
                REG_DEGREE: r_degree <= i_cfg.data[DEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Degrees above the built range fall back to the largest one.
    assign w_deg_clamped = (r_degree > DEG_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE)
                                                             : IDX_W'(r_degree);
    assign w_three = (r_dims == DIMS_3D);

    ltb_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (i_pt),
        .i_degree     (w_deg_clamped),
        .i_three      (w_three),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    ltb_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    ltb_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_pop_valid),
        .o_q_ready (w_pop_ready),
        .i_q_data  (w_pop_data),
        .o_res     (o_res)
    );

endmodule

// ----- hdl/ltb_checker.sv -----
module ltb_checker import ltb_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic signed [VAL_W-1:0] i_value,
    input logic [ROW_W-1:0]        i_index,
    input logic                    i_last
);

    // Index expected on the next result transaction.
    logic [ROW_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (i_valid && i_ready) begin
            r_exp_idx <= i_last ? '0 : i_index + 1'b1;
        end
    end

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_value) && $stable(i_index) && $stable(i_last))
        else $error("result payload changed while stalled");

    // Indexes run without gaps and restart after the final result of a point.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |-> i_index == r_exp_idx)
        else $error("basis index out of sequence");

    // The final result sits at the end of a complete 2D or 3D basis.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> (i_index == 6'd0 || i_index == 6'd2 || i_index == 6'd3 ||
                               i_index == 6'd5 || i_index == 6'd9 || i_index == 6'd14 ||
                               i_index == 6'd19 || i_index == 6'd20 ||
                               i_index == 6'd34 || i_index == 6'd55))
        else $error("last flag on an index that closes no basis");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered right after reset");

endmodule

bind legendre_tensor_basis_eval_unit ltb_checker u_ltb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_value (o_res.basis_value),
    .i_index (o_res.basis_index),
    .i_last  (o_res.last)
);
